>>> rtl/core/mcoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcoc_pkg;

   localparam int DIM_W   = 16;
   localparam int COST_W  = 63;
   localparam int SPLIT_W = 6;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef struct packed {
      logic [DIM_W-1:0] dimension;
      logic             last_dimension;
   } mcoc_req_type;

   typedef struct packed {
      logic [COST_W-1:0]  min_cost;
      logic [SPLIT_W-1:0] top_split;
      logic               overflow;
   } mcoc_rsp_type;

   // one split candidate, aligned with the memory read data
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic [SPLIT_W-1:0] k;
   } mcoc_issue_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD_LEFT,
      ST_RD_RIGHT,
      ST_SCALE,
      ST_ISSUE,
      ST_DRAIN,
      ST_WRITE,
      ST_FINISH
   } mcoc_state_type;

endpackage
`default_nettype wire

>>> rtl/core/matrix_chain_order_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// Matrix chain order cost.
// Input transfers on req_* carry one chain dimension each; last_dimension marks the
// final one. Dimensions are taken one per cycle while loading. Beyond
// MAX_MATRICES+1 stored values further dimensions are dropped and the result
// reports overflow. The final transfer starts the interval program; req_stall stays
// high until the result is placed in the output register, then loading resumes.
// The program runs each interval (i,j) of length len as a setup that reads its
// two outer dimensions and forms their product, len-1 split candidates issued
// one per cycle from the cost memory's two read ports, a drain of the arithmetic
// pipe and a write-back of the interval's best cost. Chains with fewer than two
// matrices give cost 0 and split 0 without running the program.
// One result transfer on rsp_* follows each final dimension. While rsp_stall holds
// the result, the next chain still loads and its program still runs; req_stall
// then stays high until the output register is free.
// Reset empties the dimension count, clears the overflow flag and the output
// valid flag. The memories need no clearing.
module matrix_chain_order_cost #(
   parameter int MAX_MATRICES = 32,
   parameter int DIM_BITS     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mcoc_pkg::mcoc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mcoc_pkg::mcoc_rsp_type rsp_data
);
   import mcoc_pkg::*;

   localparam int SD = MAX_MATRICES + 1;
   localparam int TD = SD * SD;
   localparam int IW = $clog2(SD);
   localparam int CW = $clog2(SD + 1);
   localparam int AW = $clog2(TD);
   localparam int D  = DIM_BITS;

   logic [D-1:0]      dim_mem [SD];
   logic [COST_W-1:0] cost_mem [TD];

   mcoc_state_type state_ff, state_in;

   logic [CW-1:0]   count_ff;
   logic            ovf_ff;
   logic            res_ovf_ff;
   logic            short_chain_ff;
   logic [IW-1:0]   n_ff;
   logic [IW-1:0]   len_ff, i_ff, j_ff, k_ff;
   logic [AW-1:0]   row_i_ff, rowk1_ff;
   logic [D-1:0]    dl_ff;
   logic [2*D-1:0]  scale_ff;
   mcoc_issue_type  issue_ff, issue_in;
   logic            rsp_valid_ff;
   mcoc_rsp_type    rsp_data_ff, rsp_data_in;

   logic [D-1:0]      dim_q;
   logic [IW-1:0]     dim_raddr;
   logic [COST_W-1:0] ca_q, cb_q;
   logic [AW-1:0]     cost_ra, cost_rb, cost_wa;
   logic              cost_we;
   logic              rsp_load;
   logic              stall_c;

   logic              req_fire;
   logic              store_ok;
   logic [CW-1:0]     count_next;
   logic              k_last;
   logic              out_free;

   logic [COST_W-1:0]  best_cost;
   logic [SPLIT_W-1:0] best_split;
   logic               pipe_busy;

   assign req_fire   = req_valid & ~stall_c;
   assign store_ok   = count_ff < CW'(SD);
   assign count_next = store_ok ? count_ff + CW'(1) : count_ff;
   assign k_last     = (k_ff + IW'(1)) == j_ff;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign cost_ra = row_i_ff + AW'(k_ff);
   assign cost_rb = rowk1_ff + AW'(j_ff);
   assign cost_wa = row_i_ff + AW'(j_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_data.last_dimension) begin
               state_in = (count_next < CW'(3)) ? ST_FINISH : ST_RD_LEFT;
            end
         end
         ST_RD_LEFT:  state_in = ST_RD_RIGHT;
         ST_RD_RIGHT: state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = (len_ff == n_ff) ? ST_FINISH : ST_RD_LEFT;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // control outputs
   always_comb begin
      stall_c   = 1'b1;
      dim_raddr = k_ff;
      issue_in  = '0;
      cost_we   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_LOAD:     stall_c = 1'b0;
         ST_RD_LEFT:  dim_raddr = i_ff - IW'(1);
         ST_RD_RIGHT: dim_raddr = j_ff;
         ST_SCALE:    dim_raddr = k_ff;
         ST_ISSUE: begin
            dim_raddr      = k_ff;
            issue_in.valid = 1'b1;
            issue_in.first = k_ff == i_ff;
            issue_in.last  = k_last;
            issue_in.k     = SPLIT_W'(k_ff);
         end
         ST_DRAIN:  dim_raddr = k_ff;
         ST_WRITE:  cost_we = 1'b1;
         ST_FINISH: rsp_load = out_free;
         default:   stall_c = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         if (req_fire) begin
            if (req_data.last_dimension) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               count_ff <= count_next;
               ovf_ff   <= ovf_ff | ~store_ok;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sequencer indices and interval setup
   always_ff @(posedge clock) begin
      if (req_fire && req_data.last_dimension) begin
         res_ovf_ff     <= ovf_ff | ~store_ok;
         short_chain_ff <= count_next < CW'(3);
         n_ff           <= IW'(count_next - CW'(1));
         len_ff         <= IW'(2);
         i_ff           <= IW'(1);
         j_ff           <= IW'(2);
         row_i_ff       <= AW'(SD);
      end
      case (state_ff)
         ST_RD_LEFT: begin
            k_ff     <= i_ff;
            rowk1_ff <= row_i_ff + AW'(SD);
         end
         ST_RD_RIGHT: dl_ff <= dim_q;
         ST_SCALE:    scale_ff <= {{D{1'b0}}, dl_ff} * {{D{1'b0}}, dim_q};
         ST_ISSUE: begin
            k_ff     <= k_ff + IW'(1);
            rowk1_ff <= rowk1_ff + AW'(SD);
         end
         ST_WRITE: begin
            if (j_ff == n_ff) begin
               len_ff   <= len_ff + IW'(1);
               i_ff     <= IW'(1);
               j_ff     <= len_ff + IW'(1);
               row_i_ff <= AW'(SD);
            end else begin
               i_ff     <= i_ff + IW'(1);
               j_ff     <= j_ff + IW'(1);
               row_i_ff <= row_i_ff + AW'(SD);
            end
         end
         default: ;
      endcase
   end

   // dimension store
   always_ff @(posedge clock) begin
      if (req_fire && store_ok) begin
         dim_mem[count_ff[IW-1:0]] <= D'(req_data.dimension);
      end
      dim_q <= dim_mem[dim_raddr];
   end

   // cost table: two reads, one write
   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_wa] <= best_cost;
      end
      ca_q <= cost_mem[cost_ra];
      cb_q <= cost_mem[cost_rb];
   end

   mcoc_cost_pipe #(
      .DIM_BITS (DIM_BITS)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue_ff),
      .scale      (scale_ff),
      .dim_k      (dim_q),
      .cost_left  (ca_q),
      .cost_right (cb_q),
      .best_cost  (best_cost),
      .best_split (best_split),
      .busy       (pipe_busy)
   );

   always_comb begin
      rsp_data_in.min_cost  = short_chain_ff ? '0 : best_cost;
      rsp_data_in.top_split = short_chain_ff ? '0 : best_split;
      rsp_data_in.overflow  = res_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_stall = stall_c;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/mcoc_cost_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module mcoc_cost_pipe #(
   parameter int DIM_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcoc_pkg::mcoc_issue_type      issue,
   input  logic [2*DIM_BITS-1:0]         scale,
   input  logic [DIM_BITS-1:0]           dim_k,
   input  logic [mcoc_pkg::COST_W-1:0]   cost_left,
   input  logic [mcoc_pkg::COST_W-1:0]   cost_right,
   output logic [mcoc_pkg::COST_W-1:0]   best_cost,
   output logic [mcoc_pkg::SPLIT_W-1:0]  best_split,
   output logic                          busy
);
   import mcoc_pkg::*;

   localparam int D  = DIM_BITS;
   localparam int PW = 3 * DIM_BITS;
   localparam int EW = (PW > COST_W) ? PW : COST_W;

   // stage 2: low partial product, subcost sum
   logic               s2_valid_ff;
   logic               s2_first_ff;
   logic [SPLIT_W-1:0] s2_k_ff;
   logic [2*D-1:0]     s2_plo_ff, s2_plo_in;
   logic [COST_W:0]    s2_csum_ff, s2_csum_in;
   logic [D-1:0]       s2_dk_ff;

   // stage 3: high partial product
   logic               s3_valid_ff;
   logic               s3_first_ff;
   logic [SPLIT_W-1:0] s3_k_ff;
   logic [2*D-1:0]     s3_plo_ff;
   logic [2*D-1:0]     s3_phi_ff, s3_phi_in;
   logic [COST_W:0]    s3_csum_ff;

   // stage 4: saturated product
   logic               s4_valid_ff;
   logic               s4_first_ff;
   logic [SPLIT_W-1:0] s4_k_ff;
   logic [COST_W-1:0]  s4_prod_ff, s4_prod_in;
   logic [COST_W:0]    s4_csum_ff;
   logic [PW-1:0]      prod_full;
   logic [EW-1:0]      prod_ext;

   // stage 5: candidate cost
   logic               s5_valid_ff;
   logic               s5_first_ff;
   logic [SPLIT_W-1:0] s5_k_ff;
   logic [COST_W-1:0]  s5_q_ff, s5_q_in;
   logic [COST_W+1:0]  q_sum;

   logic [COST_W-1:0]  best_ff;
   logic [SPLIT_W-1:0] best_k_ff;

   logic [COST_W-1:0]  left_term, right_term;

   assign left_term  = issue.first ? '0 : cost_left;
   assign right_term = issue.last  ? '0 : cost_right;
   assign s2_csum_in = {1'b0, left_term} + {1'b0, right_term};
   assign s2_plo_in  = {{D{1'b0}}, scale[D-1:0]} * {{D{1'b0}}, dim_k};

   assign s3_phi_in  = {{D{1'b0}}, scale[2*D-1:D]} * {{D{1'b0}}, s2_dk_ff};

   assign prod_full  = {s3_phi_ff, {D{1'b0}}} + {{D{1'b0}}, s3_plo_ff};
   assign prod_ext   = EW'(prod_full);
   assign s4_prod_in = (prod_ext >= EW'(COST_MAX)) ? COST_MAX : COST_W'(prod_ext);

   assign q_sum   = {2'b00, s4_prod_ff} + {1'b0, s4_csum_ff};
   assign s5_q_in = (q_sum >= (COST_W+2)'(COST_MAX)) ? COST_MAX : q_sum[COST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= issue.valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_first_ff <= issue.first;
      s2_k_ff     <= issue.k;
      s2_plo_ff   <= s2_plo_in;
      s2_csum_ff  <= s2_csum_in;
      s2_dk_ff    <= dim_k;

      s3_first_ff <= s2_first_ff;
      s3_k_ff     <= s2_k_ff;
      s3_plo_ff   <= s2_plo_ff;
      s3_phi_ff   <= s3_phi_in;
      s3_csum_ff  <= s2_csum_ff;

      s4_first_ff <= s3_first_ff;
      s4_k_ff     <= s3_k_ff;
      s4_prod_ff  <= s4_prod_in;
      s4_csum_ff  <= s3_csum_ff;

      s5_first_ff <= s4_first_ff;
      s5_k_ff     <= s4_k_ff;
      s5_q_ff     <= s5_q_in;

      // ties keep the smaller split
      if (s5_valid_ff && (s5_first_ff || (s5_q_ff < best_ff))) begin
         best_ff   <= s5_q_ff;
         best_k_ff <= s5_k_ff;
      end
   end

   assign best_cost  = best_ff;
   assign best_split = best_k_ff;
   assign busy       = issue.valid | s2_valid_ff | s3_valid_ff | s4_valid_ff | s5_valid_ff;

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import mcoc_pkg::*;

   localparam int          STORE_DEPTH  = 33;
   localparam int          RANDOM_ITEMS = 900;
   localparam int          HOLD_CYCLES  = 3000;
   localparam int          QUIET_LIMIT  = 200000;
   localparam logic [63:0] COST_CEILING = {1'b0, COST_MAX};

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

   class chain_scoreboard;
      logic [DIM_W-1:0] dims [STORE_DEPTH];
      int unsigned      count;
      bit               dropped;
      mcoc_rsp_type     awaited [$];
      int unsigned      errors;
      int unsigned      results;

      function new();
         count   = 0;
         dropped = 1'b0;
         errors  = 0;
         results = 0;
      endfunction

      function logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
         logic [63:0] s;
         if (a >= COST_CEILING || b >= COST_CEILING) return COST_CEILING;
         s = a + b;
         return (s >= COST_CEILING) ? COST_CEILING : s;
      endfunction

      function logic [63:0] clip_mul(logic [63:0] a, logic [63:0] b);
         if (a == 0 || b == 0) return 64'd0;
         if (a > COST_CEILING / b) return COST_CEILING;
         return a * b;
      endfunction

      // interval program over the stored prefix; ties keep the leftmost split
      function mcoc_rsp_type best_order();
         logic [63:0]  cost [STORE_DEPTH][STORE_DEPTH];
         int           cut  [STORE_DEPTH][STORE_DEPTH];
         logic [63:0]  q;
         int           n;
         int           j;
         mcoc_rsp_type r;
         r          = '0;
         r.overflow = dropped;
         n          = (count > 0) ? int'(count) - 1 : 0;
         if (n >= 2) begin
            for (int i = 1; i <= n; i++) begin
               cost[i][i] = 64'd0;
               cut[i][i]  = 0;
            end
            for (int len = 2; len <= n; len++) begin
               for (int i = 1; i + len - 1 <= n; i++) begin
                  j = i + len - 1;
                  for (int k = i; k < j; k++) begin
                     q = clip_mul(clip_mul(dims[i-1], dims[k]), dims[j]);
                     q = clip_add(q, clip_add(cost[i][k], cost[k+1][j]));
                     if (k == i || q < cost[i][j]) begin
                        cost[i][j] = q;
                        cut[i][j]  = k;
                     end
                  end
               end
            end
            r.min_cost  = cost[1][n][COST_W-1:0];
            r.top_split = SPLIT_W'(cut[1][n]);
         end
         return r;
      endfunction

      function void note_dimension(mcoc_req_type t);
         if (count < STORE_DEPTH) begin
            dims[count] = t.dimension;
            count++;
         end else begin
            dropped = 1'b1;
         end
         if (t.last_dimension) begin
            awaited.push_back(best_order());
            count   = 0;
            dropped = 1'b0;
         end
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10)
            $display("tb: result %0d %s expected %0d got %0d", results, what, want, got);
      endfunction

      function void check_result(mcoc_rsp_type got);
         mcoc_rsp_type want;
         results++;
         if (awaited.size() == 0) begin
            flag("unexpected transfer, min_cost", 64'd0, 64'(got.min_cost));
            return;
         end
         want = awaited.pop_front();
         if (got.min_cost !== want.min_cost)
            flag("min_cost", 64'(want.min_cost), 64'(got.min_cost));
         if (got.top_split !== want.top_split)
            flag("top_split", 64'(want.top_split), 64'(got.top_split));
         if (got.overflow !== want.overflow)
            flag("overflow", 64'(want.overflow), 64'(got.overflow));
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   mcoc_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   mcoc_rsp_type rsp_data;

   chain_scoreboard  sb           = new();
   logic [DIM_W-1:0] chain_dims [$];
   int unsigned      burst_left   = 0;
   int unsigned      quiet_cycles = 0;

   matrix_chain_order_cost uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic offer(input logic [DIM_W-1:0] dim, input logic fin);
      if (burst_left == 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 64);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{dimension: dim, last_dimension: fin};
      do @(posedge clock); while (req_stall);
      sb.note_dimension(req_data);
   endtask

   task automatic send_chain();
      foreach (chain_dims[i])
         offer(chain_dims[i], i == chain_dims.size() - 1);
   endtask

   function automatic logic [DIM_W-1:0] pick_dimension();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return '0;
      if (roll < 10) return DIM_W'(17'h0FFFF - $urandom_range(0, 1));
      if (roll < 14) return DIM_W'(1);
      if (roll < 50) return DIM_W'($urandom_range(1, 16));
      if (roll < 65) return DIM_W'($urandom_range(1, 255));
      return DIM_W'($urandom_range(0, 65535));
   endfunction

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: stall patterns, plus one long hold-off so the input backs up
   initial begin : receiver
      rx_mode_e    mode;
      int unsigned span;
      bit          held;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (!held && sb.results >= 12) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = rx_mode_e'($urandom_range(0, 3));
         span = $urandom_range(16, 400);
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            case (mode)
               RX_OPEN:    rsp_stall <= 1'b0;
               RX_LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
               RX_PATTERN: rsp_stall <= ((c % 7) < 3);
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned chains;
      int unsigned len;
      int unsigned roll;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // lone final dimension, single matrix, widest dims, textbook chain,
      // zero dims with tied splits, alternating extremes
      chain_dims = '{16'd7};
      send_chain();
      chain_dims = '{16'hFFFF, 16'hFFFF};
      send_chain();
      chain_dims = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
      send_chain();
      chain_dims = '{16'd40, 16'd20, 16'd30, 16'd10, 16'd30};
      send_chain();
      chain_dims = '{16'd0, 16'd5, 16'd0, 16'd7};
      send_chain();
      chain_dims = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1};
      send_chain();

      // full store first, then one past it so the final transfer is dropped
      sent   = 0;
      chains = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (chains == 0) len = STORE_DEPTH;
         else if (chains == 1) len = STORE_DEPTH + 1;
         else if (roll < 70) len = $urandom_range(1, 10);
         else if (roll < 94) len = $urandom_range(11, STORE_DEPTH);
         else len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 7);
         chain_dims.delete();
         repeat (len) chain_dims.push_back(pick_dimension());
         send_chain();
         sent += len;
         chains++;
      end

      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

>>> matrix_chain_order_cost.f
rtl/core/mcoc_pkg.sv
rtl/core/mcoc_cost_pipe.sv
rtl/core/matrix_chain_order_cost.sv
sim/tb.sv
